// ===== rtl/timed_task_slot_table_macros.svh =====
// assertion macros shared by the checker
`ifndef TIMED_TASK_SLOT_TABLE_MACROS_SVH
`define TIMED_TASK_SLOT_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define TTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tts assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define TTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tts assertion failed");

`endif

// ===== rtl/tts_pkg.sv =====
`default_nettype none

package tts_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int MAX_FIRES  = 16;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int FIRE_W     = $clog2(MAX_FIRES + 1);
  localparam int TIME_W     = 32;
  localparam int MS_W       = 15;
  localparam int SLOT_W     = 4;
  localparam int KIND_W     = 2;
  localparam int REQ_W      = 2;

  localparam logic [REQ_W-1:0] REQ_SCAN   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CREATE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_END    = 2'd2;

  localparam logic [KIND_W-1:0] EV_CREATE = 2'd0;
  localparam logic [KIND_W-1:0] EV_FIRE   = 2'd1;
  localparam logic [KIND_W-1:0] EV_END    = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [TIME_W-1:0] now_time;
    logic [MS_W-1:0]   delay_ms;
    logic [MS_W-1:0]   period_ms;
    logic [SLOT_W-1:0] target_slot;
  } req_t;

  // walk token handed from cell to cell
  typedef struct packed {
    logic              active;
    logic              taken;
    idx_t              slot;
    logic [FIRE_W-1:0] fires;
  } token_t;

  function automatic logic [SLOT_W-1:0] slot_field(idx_t idx);
    logic [IDX_W+SLOT_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, idx};
    return wide[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tts_req_if.sv =====
`default_nettype none

interface tts_req_if import tts_pkg::*;;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [TIME_W-1:0] now_time;
  logic [MS_W-1:0]   delay_ms;
  logic [MS_W-1:0]   period_ms;
  logic [SLOT_W-1:0] target_slot;

  modport source (
    output valid, req_type, now_time, delay_ms, period_ms, target_slot,
    input  ready
  );
  modport sink (
    input  valid, req_type, now_time, delay_ms, period_ms, target_slot,
    output ready
  );
endinterface

interface tts_evt_if import tts_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [SLOT_W-1:0] slot_index;
  logic              no_free_slot;
  logic              last_of_run;

  modport source (
    output valid, event_kind, slot_index, no_free_slot, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, event_kind, slot_index, no_free_slot, last_of_run,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/tts_cell.sv =====
`default_nettype none

module tts_cell import tts_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  idx_t   cell_index,
  input  req_t   req,
  input  token_t tok_in,
  output token_t tok_out,
  output logic   fire
);

  token_t            tok_q;
  logic              enabled;
  logic              enabled_next;
  logic [TIME_W-1:0] due_time;
  logic [TIME_W-1:0] due_time_next;
  logic [MS_W-1:0]   period;
  logic [MS_W-1:0]   period_next;
  logic              hit;
  logic              target_match;

  assign hit = enabled && (due_time <= req.now_time) &&
               (tok_q.fires < FIRE_W'(MAX_FIRES));
  assign target_match = ({{SLOT_W{1'b0}}, cell_index} ==
                         {{IDX_W{1'b0}}, req.target_slot});

  always_comb begin
    tok_out       = tok_q;
    fire          = 1'b0;
    enabled_next  = enabled;
    due_time_next = due_time;
    period_next   = period;
    if (tok_q.active) begin
      unique case (req.req_type)
        REQ_SCAN: begin
          if (hit) begin
            fire          = 1'b1;
            tok_out.fires = tok_q.fires + 1'b1;
            if (period != '0) begin
              due_time_next = req.now_time + {{(TIME_W-MS_W){1'b0}}, period};
            end else begin
              enabled_next = 1'b0;
            end
          end
        end
        REQ_CREATE: begin
          if (!enabled && !tok_q.taken) begin
            enabled_next  = 1'b1;
            due_time_next = req.now_time + {{(TIME_W-MS_W){1'b0}}, req.delay_ms};
            period_next   = req.period_ms;
            tok_out.taken = 1'b1;
            tok_out.slot  = cell_index;
          end
        end
        REQ_END: begin
          if (target_match) begin
            enabled_next = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q   <= '0;
      enabled <= 1'b0;
      period  <= '0;
    end else if (adv) begin
      tok_q   <= tok_in;
      enabled <= enabled_next;
      period  <= period_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      due_time <= due_time_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/timed_task_slot_table.sv =====
// timer slot table, one slot per cell in a chain
//
// req channel: one transaction per request (scan, create, end); evt channel
// carries the results. a request walks a token through all SLOT_COUNT cells,
// one cell per cycle while evt does not stall the chain, then through the done
// register into the output register; the next request is accepted once the
// walk is done and its final result, if any, sits in the output register.
// create and end give one result at the end of the walk. a scan gives one
// fire per due slot in slot order, each held back by one slot so the last
// one can carry last_of_run; a scan with nothing due gives no transaction.
// unknown request codes walk the chain and give nothing.
// reset empties the table and the output register; no clearing pass is
// needed, so req.ready is high in the first cycle after reset.
// when evt stalls, the token freezes at a cell that wants to fire while
// the output register and the held fire are both occupied; nothing is lost.
`default_nettype none

module timed_task_slot_table import tts_pkg::*; (
  input logic      clk,
  input logic      rst,
  tts_req_if.sink  req,
  tts_evt_if.source evt
);

  logic                  busy;
  req_t                  req_q;
  token_t                launch_tok;
  token_t                tok_chain [SLOT_COUNT];
  token_t                done;
  logic [SLOT_COUNT-1:0] fire_vec;
  logic                  fire_any;
  idx_t                  fire_idx;
  logic                  pend_valid;
  idx_t                  pend_idx;
  logic                  out_valid;
  logic [KIND_W-1:0]     out_kind;
  logic [SLOT_W-1:0]     out_index;
  logic                  out_nofree;
  logic                  out_last;
  logic                  accept;
  logic                  out_free;
  logic                  stall;
  logic                  adv;
  logic                  finish;

  assign req.ready  = !busy;
  assign accept     = req.valid && !busy;
  assign out_free   = !out_valid || evt.ready;
  assign stall      = fire_any && pend_valid && !out_free;
  assign adv        = !stall;
  assign finish     = done.active && out_free;

  always_comb begin
    launch_tok        = '0;
    launch_tok.active = accept;
  end

  genvar g;
  generate
    for (g = 0; g < SLOT_COUNT; g++) begin : g_cell
      if (g == 0) begin : g_head
        tts_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .adv        (adv),
          .cell_index (IDX_W'(g)),
          .req        (req_q),
          .tok_in     (launch_tok),
          .tok_out    (tok_chain[g]),
          .fire       (fire_vec[g])
        );
      end else begin : g_body
        tts_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .adv        (adv),
          .cell_index (IDX_W'(g)),
          .req        (req_q),
          .tok_in     (tok_chain[g-1]),
          .tok_out    (tok_chain[g]),
          .fire       (fire_vec[g])
        );
      end
    end
  endgenerate

  always_comb begin
    fire_any = 1'b0;
    fire_idx = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      fire_any = fire_any | fire_vec[i];
      if (fire_vec[i]) begin
        fire_idx = fire_idx | IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q.req_type    <= req.req_type;
      req_q.now_time    <= req.now_time;
      req_q.delay_ms    <= req.delay_ms;
      req_q.period_ms   <= req.period_ms;
      req_q.target_slot <= req.target_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && evt.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        busy <= 1'b1;
      end
      if (adv && tok_chain[SLOT_COUNT-1].active) begin
        done <= tok_chain[SLOT_COUNT-1];
      end
      if (adv && fire_any) begin
        if (pend_valid) begin
          out_valid  <= 1'b1;
          out_kind   <= EV_FIRE;
          out_index  <= slot_field(pend_idx);
          out_nofree <= 1'b0;
          out_last   <= 1'b0;
        end
        pend_valid <= 1'b1;
        pend_idx   <= fire_idx;
      end
      if (finish) begin
        done <= '0;
        busy <= 1'b0;
        unique case (req_q.req_type)
          REQ_SCAN: begin
            if (pend_valid) begin
              out_valid  <= 1'b1;
              out_kind   <= EV_FIRE;
              out_index  <= slot_field(pend_idx);
              out_nofree <= 1'b0;
              out_last   <= 1'b1;
              pend_valid <= 1'b0;
            end
          end
          REQ_CREATE: begin
            out_valid  <= 1'b1;
            out_kind   <= EV_CREATE;
            out_index  <= done.taken ? slot_field(done.slot) : '0;
            out_nofree <= !done.taken;
            out_last   <= 1'b1;
          end
          REQ_END: begin
            out_valid  <= 1'b1;
            out_kind   <= EV_END;
            out_index  <= req_q.target_slot;
            out_nofree <= 1'b0;
            out_last   <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  assign evt.valid        = out_valid;
  assign evt.event_kind   = out_kind;
  assign evt.slot_index   = out_index;
  assign evt.no_free_slot = out_nofree;
  assign evt.last_of_run  = out_last;

endmodule

`default_nettype wire

// ===== rtl/tts_checker.sv =====
`default_nettype none
`include "timed_task_slot_table_macros.svh"

module tts_checker import tts_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              evt_valid,
  input logic              evt_ready,
  input logic [KIND_W-1:0] event_kind,
  input logic [SLOT_W-1:0] slot_index,
  input logic              no_free_slot,
  input logic              last_of_run
);

  // a stalled result holds
  `TTS_ASSERT_NEXT(a_evt_hold, evt_valid && !evt_ready,
    evt_valid && $stable({event_kind, slot_index, no_free_slot, last_of_run}))

  // one request at a time
  `TTS_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

  // full-table create reads as slot zero and closes its run
  `TTS_ASSERT_NOW(a_nofree_shape, evt_valid && no_free_slot,
    event_kind == EV_CREATE && slot_index == '0 && last_of_run)

  // acknowledges are always single results
  `TTS_ASSERT_NOW(a_ack_last, evt_valid && event_kind != EV_FIRE, last_of_run)

endmodule

bind timed_task_slot_table tts_checker u_tts_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .evt_valid    (evt.valid),
  .evt_ready    (evt.ready),
  .event_kind   (evt.event_kind),
  .slot_index   (evt.slot_index),
  .no_free_slot (evt.no_free_slot),
  .last_of_run  (evt.last_of_run)
);

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tts_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 420;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic              nofree;
    logic              last;
  } timer_evt_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tts_req_if req_ch ();
  tts_evt_if evt_ch ();

  timed_task_slot_table u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .evt(evt_ch)
  );

  // shadow copy of the timer table
  logic              slot_on  [SLOT_COUNT];
  logic [TIME_W-1:0] slot_due [SLOT_COUNT];
  logic [MS_W-1:0]   slot_per [SLOT_COUNT];
  timer_evt_t        timer_evts_due [$];

  logic [TIME_W-1:0] ms_clock;
  bit src_idle_en;
  bit sink_idle_en;
  int sink_hold = 0;
  int sink_gap = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int n_create = 0;
  int n_full = 0;
  int n_end = 0;
  int n_scan = 0;
  int n_quiet = 0;
  int n_fire = 0;
  int n_evt = 0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic timer_evt_t make_evt(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                                          logic nofree, logic last);
    timer_evt_t e;
    e.kind = kind;
    e.slot = slot;
    e.nofree = nofree;
    e.last = last;
    return e;
  endfunction

  function automatic req_t make_req(logic [REQ_W-1:0] kind, logic [TIME_W-1:0] now,
                                    logic [MS_W-1:0] delay, logic [MS_W-1:0] period,
                                    logic [SLOT_W-1:0] target);
    req_t r;
    r.req_type = kind;
    r.now_time = now;
    r.delay_ms = delay;
    r.period_ms = period;
    r.target_slot = target;
    return r;
  endfunction

  // update the shadow table and queue the transactions the request causes
  function automatic void apply_timer_request(req_t r);
    int fired [$];
    int free_slot;
    free_slot = -1;
    case (r.req_type)
      REQ_SCAN: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slot_on[i] && slot_due[i] <= r.now_time && fired.size() < MAX_FIRES) begin
            fired.push_back(i);
            if (slot_per[i] != '0) slot_due[i] = r.now_time + TIME_W'(slot_per[i]);
            else slot_on[i] = 1'b0;
          end
        end
        n_scan++;
        if (fired.size() == 0) n_quiet++;
        foreach (fired[k]) begin
          timer_evts_due.push_back(make_evt(EV_FIRE, SLOT_W'(fired[k]), 1'b0,
                                            k == fired.size() - 1));
        end
      end
      REQ_CREATE: begin
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
          if (!slot_on[i]) free_slot = i;
        end
        n_create++;
        if (free_slot < 0) begin
          n_full++;
          timer_evts_due.push_back(make_evt(EV_CREATE, '0, 1'b1, 1'b1));
        end else begin
          slot_on[free_slot] = 1'b1;
          slot_due[free_slot] = r.now_time + TIME_W'(r.delay_ms);
          slot_per[free_slot] = r.period_ms;
          timer_evts_due.push_back(make_evt(EV_CREATE, SLOT_W'(free_slot), 1'b0, 1'b1));
        end
      end
      REQ_END: begin
        if (int'(r.target_slot) < SLOT_COUNT) slot_on[r.target_slot] = 1'b0;
        n_end++;
        timer_evts_due.push_back(make_evt(EV_END, r.target_slot, 1'b0, 1'b1));
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_request(req_t r);
    int gap;
    gap = src_idle_en ? $urandom_range(0, 6) : 0;
    repeat (gap) @(negedge clk);
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.req_type <= r.req_type;
    req_ch.now_time <= r.now_time;
    req_ch.delay_ms <= r.delay_ms;
    req_ch.period_ms <= r.period_ms;
    req_ch.target_slot <= r.target_slot;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    apply_timer_request(r);
    @(negedge clk);
    req_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (timer_evts_due.size() != 0) @(posedge clk);
  endtask

  // receiver side: long hold first, then the per-transaction gap
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      evt_ch.ready <= 1'b0;
      sink_hold--;
    end else if (sink_gap > 0) begin
      evt_ch.ready <= 1'b0;
      sink_gap--;
    end else begin
      evt_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    timer_evt_t got;
    timer_evt_t want;
    if (!rst && evt_ch.valid && evt_ch.ready) begin
      got = make_evt(evt_ch.event_kind, evt_ch.slot_index, evt_ch.no_free_slot,
                     evt_ch.last_of_run);
      sink_gap = sink_idle_en ? $urandom_range(0, 6) : 0;
      n_evt++;
      if (got.kind == EV_FIRE) n_fire++;
      if (timer_evts_due.size() == 0) begin
        $error("unexpected transaction: event_kind %0d slot_index %0d", got.kind, got.slot);
        fail_count++;
      end else begin
        want = timer_evts_due.pop_front();
        if (got.kind !== want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, got.kind);
          fail_count++;
        end
        if (got.slot !== want.slot) begin
          $error("slot_index: expected %0d, got %0d", want.slot, got.slot);
          fail_count++;
        end
        if (got.nofree !== want.nofree) begin
          $error("no_free_slot: expected %0d, got %0d", want.nofree, got.nofree);
          fail_count++;
        end
        if (got.last !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, got.last);
          fail_count++;
        end
      end
    end
  end

  function automatic req_t random_request();
    req_t r;
    int pick;
    int on_list [$];
    r.req_type = REQ_SCAN;
    r.now_time = $urandom;
    r.delay_ms = MS_W'($urandom);
    r.period_ms = MS_W'($urandom);
    r.target_slot = SLOT_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      r.req_type = REQ_CREATE;
      r.now_time = ms_clock;
      r.delay_ms = ($urandom_range(0, 19) == 0) ? MS_W'($urandom) : MS_W'($urandom_range(0, 40));
      r.period_ms = ($urandom_range(0, 2) == 0) ? '0 : MS_W'($urandom_range(1, 60));
    end else if (pick < 58) begin
      ms_clock = ms_clock + TIME_W'($urandom_range(0, 30));
      r.req_type = REQ_SCAN;
      r.now_time = ms_clock;
    end else if (pick < 75) begin
      r.req_type = REQ_END;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (slot_on[i]) on_list.push_back(i);
      end
      if (on_list.size() != 0 && $urandom_range(0, 4) != 0) begin
        r.target_slot = SLOT_W'(on_list[$urandom_range(0, on_list.size() - 1)]);
      end
    end else begin
      // noise: any code, any field value
      r.req_type = REQ_W'($urandom_range(0, 3));
    end
    return r;
  endfunction

  task automatic test_directed_ops();
    send_request(make_req(REQ_CREATE, 32'd100, '0, '0, '0));
    send_request(make_req(REQ_SCAN, 32'd100, '0, '0, '0));
    send_request(make_req(REQ_SCAN, 32'd100, '0, '0, '0));
    send_request(make_req(REQ_UNUSED, '1, '1, '1, '1));
    send_request(make_req(REQ_END, 32'd5, '0, '0, 4'd15));
    // due time wraps past zero and compares low
    send_request(make_req(REQ_CREATE, 32'hFFFF_FFF0, '1, '1, '0));
    send_request(make_req(REQ_SCAN, '1, '0, '0, '0));
  endtask

  task automatic test_full_table();
    for (int i = 1; i < SLOT_COUNT; i++) begin
      send_request(make_req(REQ_CREATE, 32'h8000_0000, MS_W'(i * 1000),
                            (i % 2) ? MS_W'(i) : '0, '0));
    end
    send_request(make_req(REQ_CREATE, 32'h8000_0000, '0, '0, '0));
    send_request(make_req(REQ_SCAN, '1, '0, '0, '0));
    send_request(make_req(REQ_END, '0, '0, '0, '0));
  endtask

  task automatic test_random_traffic();
    req_t r;
    int sent;
    int items;
    sent = 0;
    items = 0;
    for (int half = 1; half <= 2; half++) begin
      while (sent < half * RANDOM_ITEMS / 2) begin
        if (items % 40 == 0) begin
          src_idle_en = $urandom_range(0, 3) != 0;
          sink_idle_en = $urandom_range(0, 3) != 0;
        end
        r = random_request();
        send_request(r);
        items++;
        if (r.req_type != REQ_UNUSED) sent++;
      end
      // sender pauses until everything has come back
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    @(posedge clk);
    src_idle_en = 1'b0;
    sink_idle_en = 1'b1;
    sink_hold = HOLD_CYCLES;
    for (int i = 0; i < 12; i++) begin
      send_request(make_req(REQ_CREATE, ms_clock, MS_W'($urandom_range(0, 40)),
                            MS_W'($urandom_range(0, 5)), SLOT_W'($urandom)));
    end
    wait_drained();
    src_idle_en = 1'b1;
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_SCAN;
    req_ch.now_time = '0;
    req_ch.delay_ms = '0;
    req_ch.period_ms = '0;
    req_ch.target_slot = '0;
    evt_ch.ready = 1'b0;
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    ms_clock = 32'h0001_0000;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_on[i] = 1'b0;
      slot_due[i] = '0;
      slot_per[i] = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_ops();
    test_full_table();
    test_random_traffic();
    test_backpressure();

    wait_drained();
    repeat (4 * SLOT_COUNT) @(posedge clk);
    $display("summary: %0d creates (%0d on a full table), %0d ends, %0d scans (%0d quiet)",
             n_create, n_full, n_end, n_scan, n_quiet);
    $display("summary: %0d result transactions checked, %0d of them fires, %0d errors",
             n_evt, n_fire, fail_count);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/tts_pkg.sv
rtl/tts_req_if.sv
rtl/tts_cell.sv
rtl/timed_task_slot_table.sv
rtl/tts_checker.sv
test/tb.sv
